/* rtl/core/particle_pool_update_macros.svh */
// Assertion macros used by the particle pool RTL.
`ifndef PARTICLE_POOL_UPDATE_MACROS_SVH
`define PARTICLE_POOL_UPDATE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ppu_pkg.sv */
// Types, codes and arithmetic helpers for the particle pool.
`default_nettype none

package ppu_pkg;

    localparam int POOL_SIZE_DEF = 64;
    localparam int POOL_CAP      = 64;
    localparam int SLOT_W        = 6;
    localparam int GRP_N         = 8;
    localparam int GRP_W         = 3;

    // Velocity decay factor 0.92 in unsigned Q0.16.
    localparam logic [15:0] DECAY_NUM = 16'd60293;

    localparam logic [1:0] ACT_SPAWN  = 2'd0;
    localparam logic [1:0] ACT_RING   = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [1:0] REP_PLACED = 2'd0;
    localparam logic [1:0] REP_DROP   = 2'd1;
    localparam logic [1:0] REP_STATE  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] life;
        logic [31:0] size;
        logic [31:0] rate;
        logic [31:0] color;
    } slot_rec_t;

    typedef struct packed {
        logic [1:0]        report;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       pos_x;
        logic [31:0]       pos_y;
        logic [31:0]       size;
        logic [31:0]       color;
        logic              kind;
        logic [31:0]       life;
        logic              last;
    } result_t;

    function automatic logic [31:0] sat_add_s(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        logic [31:0] r;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            r = s[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_add_u(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Magnitude times 0.92, truncated, sign restored: rounds toward zero.
    function automatic logic [31:0] decay(input logic [31:0] v);
        logic [31:0] mag;
        logic [47:0] prod;
        logic [31:0] p;
        mag  = v[31] ? (~v + 32'd1) : v;
        prod = {16'd0, mag} * {32'd0, DECAY_NUM};
        p    = prod[47:16];
        return v[31] ? (~p + 32'd1) : p;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/particle_pool_update.sv */
// Fixed pool of particle slots: spawn placement and per-frame slot update.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_stall | action, pos, vel, life, color, size, rate, ft
//   out     | output    | out_valid/out_stall | report, slot, pos, size, color, kind, life, last
//
// A spawn passes through capture, a registered free-slot search, then placement.
// A tick skips each inactive slot; an active slot is first read from slot memory, then
// updated and written back. The tick opens with the capture and ends by seeing the end
// of the pool and releasing the final result.
// The split read and update of an active slot follow from the single slot memory.
// Reset clears the slot activity bits at once; the slot memory itself is not cleared.
// Output stall holds a surviving slot's update, while a result is held, until the output register frees.
`default_nettype none
`include "particle_pool_update_macros.svh"

module particle_pool_update
    import ppu_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               action,
    input  logic signed [31:0]       pos_x,
    input  logic signed [31:0]       pos_y,
    input  logic signed [31:0]       vel_x,
    input  logic signed [31:0]       vel_y,
    input  logic [31:0]              life_max,
    input  logic [31:0]              color,
    input  logic [31:0]              size,
    input  logic [31:0]              expand_rate,
    input  logic [31:0]              frame_time,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               report,
    output logic [SLOT_W-1:0]        slot,
    output logic signed [31:0]       out_pos_x,
    output logic signed [31:0]       out_pos_y,
    output logic [31:0]              out_size,
    output logic [31:0]              out_color,
    output logic                     particle_kind,
    output logic [31:0]              out_life,
    output logic                     last
);

    localparam int AW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SRCH  = 3'd1;
    localparam logic [2:0] ST_SPAWN = 3'd2;
    localparam logic [2:0] ST_TREAD = 3'd3;
    localparam logic [2:0] ST_TCALC = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [POOL_SIZE-1:0] active_reg, active_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic                 held_valid_reg, held_valid_next;
    result_t              held_reg, held_next;

    // Captured input transaction.
    slot_rec_t            new_rec_reg;
    logic [31:0]          ft_reg;

    // Free-slot search, first level registered per group of eight.
    logic [POOL_CAP-1:0]        free_vec;
    logic [GRP_N-1:0]           grp_any, grp_any_reg;
    logic [GRP_N-1:0][GRP_W-1:0] grp_idx, grp_idx_reg;
    logic                       sp_found;
    logic [SLOT_W-1:0]          sp_slot;

    // Slot memory.
    slot_rec_t            slot_mem [POOL_SIZE];
    slot_rec_t            rd_q;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_wa, mem_ra;
    slot_rec_t            mem_wd;

    slot_rec_t            upd;
    logic                 survive;
    logic                 out_free;
    result_t              tick_res;

    genvar gi;
    generate
        for (gi = 0; gi < POOL_CAP; gi++) begin : g_free
            if (gi < POOL_SIZE) begin : g_used
                assign free_vec[gi] = ~active_reg[gi];
            end
            else begin : g_unused
                assign free_vec[gi] = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_any[g] = |free_vec[g*GRP_N +: GRP_N];
            grp_idx[g] = '0;
            for (int j = GRP_N - 1; j >= 0; j--)
            begin
                if (free_vec[g*GRP_N + j])
                    grp_idx[g] = GRP_W'(j);
            end
        end
    end

    always_comb
    begin
        sp_found = |grp_any_reg;
        sp_slot  = '0;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
                sp_slot = {GRP_W'(g), grp_idx_reg[g]};
        end
    end

    // Slot update for a tick.
    always_comb
    begin
        upd       = rd_q;
        upd.pos_x = sat_add_s(rd_q.pos_x, rd_q.vel_x);
        upd.pos_y = sat_add_s(rd_q.pos_y, rd_q.vel_y);
        upd.vel_x = decay(rd_q.vel_x);
        upd.vel_y = decay(rd_q.vel_y);
        upd.life  = (ft_reg >= rd_q.life) ? 32'd0 : (rd_q.life - ft_reg);
        if (rd_q.kind)
            upd.size = sat_add_u(rd_q.size, rd_q.rate);
        survive = (upd.life != 32'd0);

        tick_res.report = REP_STATE;
        tick_res.slot   = SLOT_W'(idx_reg[AW-1:0]);
        tick_res.pos_x  = upd.pos_x;
        tick_res.pos_y  = upd.pos_y;
        tick_res.size   = upd.size;
        tick_res.color  = upd.color;
        tick_res.kind   = upd.kind;
        tick_res.life   = upd.life;
        tick_res.last   = 1'b0;
    end

    assign out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        out_next        = out_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg & out_stall;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_wa          = idx_reg[AW-1:0];
        mem_ra          = idx_reg[AW-1:0];
        mem_wd          = upd;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    if (action == ACT_SPAWN || action == ACT_RING)
                        state_next = ST_SRCH;
                    else if (action == ACT_TICK)
                        state_next = ST_TREAD;
                end
            end
            ST_SRCH:
            begin
                state_next = ST_SPAWN;
            end
            ST_SPAWN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.last  = 1'b1;
                    if (sp_found)
                    begin
                        mem_we                   = 1'b1;
                        mem_wa                   = sp_slot[AW-1:0];
                        mem_wd                   = new_rec_reg;
                        active_next[sp_slot[AW-1:0]] = 1'b1;
                        out_next.report          = REP_PLACED;
                        out_next.slot            = sp_slot;
                        out_next.pos_x           = new_rec_reg.pos_x;
                        out_next.pos_y           = new_rec_reg.pos_y;
                        out_next.size            = new_rec_reg.size;
                        out_next.color           = new_rec_reg.color;
                        out_next.kind            = new_rec_reg.kind;
                        out_next.life            = new_rec_reg.life;
                    end
                    else
                    begin
                        out_next        = '0;
                        out_next.report = REP_DROP;
                        out_next.last   = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_TREAD:
            begin
                if (idx_reg == CNT_W'(POOL_SIZE))
                    state_next = ST_FLUSH;
                else if (active_reg[idx_reg[AW-1:0]])
                begin
                    mem_re     = 1'b1;
                    state_next = ST_TCALC;
                end
                else
                    idx_next = idx_reg + CNT_W'(1);
            end
            ST_TCALC:
            begin
                // A surviving slot waits while the held result cannot move out.
                if (!survive || !held_valid_reg || out_free)
                begin
                    mem_we = 1'b1;
                    if (!survive)
                        active_next[idx_reg[AW-1:0]] = 1'b0;
                    else
                    begin
                        if (held_valid_reg)
                        begin
                            out_next       = held_reg;
                            out_valid_next = 1'b1;
                        end
                        held_next       = tick_res;
                        held_valid_next = 1'b1;
                    end
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_TREAD;
                end
            end
            ST_FLUSH:
            begin
                if (!held_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_next        = held_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        held_reg    <= held_next;
        grp_any_reg <= grp_any;
        grp_idx_reg <= grp_idx;
        if (state_reg == ST_IDLE && in_valid)
        begin
            ft_reg            <= frame_time;
            new_rec_reg.kind  <= (action == ACT_RING);
            new_rec_reg.pos_x <= $unsigned(pos_x);
            new_rec_reg.pos_y <= $unsigned(pos_y);
            new_rec_reg.vel_x <= (action == ACT_RING) ? 32'd0 : $unsigned(vel_x);
            new_rec_reg.vel_y <= (action == ACT_RING) ? 32'd0 : $unsigned(vel_y);
            new_rec_reg.life  <= life_max;
            new_rec_reg.size  <= size;
            new_rec_reg.rate  <= (action == ACT_RING) ? expand_rate : 32'd0;
            new_rec_reg.color <= color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_q <= slot_mem[mem_ra];
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign report        = out_reg.report;
    assign slot          = out_reg.slot;
    assign out_pos_x     = $signed(out_reg.pos_x);
    assign out_pos_y     = $signed(out_reg.pos_y);
    assign out_size      = out_reg.size;
    assign out_color     = out_reg.color;
    assign particle_kind = out_reg.kind;
    assign out_life      = out_reg.life;
    assign last          = out_reg.last;

    `PPU_ASSERT_NOW(a_spawn_free, (state_reg == ST_SPAWN) && mem_we, !active_reg[mem_wa], "spawn overwrote an active slot")
    `PPU_ASSERT_NOW(a_calc_active, state_reg == ST_TCALC, active_reg[idx_reg[AW-1:0]], "tick update on an inactive slot")
    `PPU_ASSERT_NOW(a_not_last_pending, out_valid_reg && !out_reg.last, held_valid_reg, "non-final result without a successor")
    `PPU_ASSERT_NEXT(a_flush_empty, (state_reg == ST_FLUSH) && (state_next == ST_IDLE), !held_valid_reg, "tick ended with a held result")

endmodule

`default_nettype wire
